@@ hw/rtl/rbst_pkg.sv @@
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] inv_dir_x;
        logic signed [COORD_WIDTH-1:0] inv_dir_y;
        logic signed [COORD_WIDTH-1:0] inv_dir_z;
        logic                          neg_x;
        logic                          neg_y;
        logic                          neg_z;
    } request_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] t_near;
        logic signed [COORD_WIDTH-1:0] t_far;
    } result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] tn;
        logic signed [COORD_WIDTH-1:0] tf;
    } axis_t;

endpackage

@@ hw/rtl/rbst_slab.sv @@
module rbst_slab #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic signed [rbst_pkg::COORD_WIDTH-1:0] lo_b,
    input  logic signed [rbst_pkg::COORD_WIDTH-1:0] hi_b,
    input  logic signed [rbst_pkg::COORD_WIDTH-1:0] org,
    input  logic signed [rbst_pkg::COORD_WIDTH-1:0] inv,
    input  logic                                    neg,
    output rbst_pkg::axis_t                         t
);

    localparam int W  = rbst_pkg::COORD_WIDTH;
    localparam int H  = W / 2;
    localparam int DW = W + 1;
    localparam int LW = DW + H + 1;
    localparam int HW = DW + W - H;
    localparam int PW = 2 * W + 1;
    localparam int SW = PW - FRAC_BITS;

    // index 0: near bound, index 1: far bound
    logic signed [DW-1:0] diff_reg [2];
    logic signed [DW-1:0] diff_next [2];
    logic signed [W-1:0]  inv_reg;
    logic signed [LW-1:0] pp_lo_reg [2];
    logic signed [LW-1:0] pp_lo_next [2];
    logic signed [HW-1:0] pp_hi_reg [2];
    logic signed [HW-1:0] pp_hi_next [2];
    logic signed [PW-1:0] prod_reg [2];
    logic signed [PW-1:0] prod_next [2];
    logic signed [W-1:0]  dist_reg [2];
    logic signed [W-1:0]  dist_next [2];
    logic signed [PW-1:0] shifted [2];
    logic signed [SW-1:0] floor_val [2];
    logic signed [W-1:0]  nb;
    logic signed [W-1:0]  fb;

    always_comb
    begin
        nb = neg ? hi_b : lo_b;
        fb = neg ? lo_b : hi_b;
        diff_next[0] = DW'(nb) - DW'(org);
        diff_next[1] = DW'(fb) - DW'(org);
        for (int i = 0; i < 2; i++)
        begin
            pp_lo_next[i] = LW'(diff_reg[i] * $signed({1'b0, inv_reg[H-1:0]}));
            pp_hi_next[i] = HW'(diff_reg[i] * $signed(inv_reg[W-1:H]));
            prod_next[i]  = (PW'(pp_hi_reg[i]) <<< H) + PW'(pp_lo_reg[i]);
            shifted[i]    = prod_reg[i] >>> FRAC_BITS;
            floor_val[i]  = shifted[i][SW-1:0];
            if ((&floor_val[i][SW-1:W-1]) || !(|floor_val[i][SW-1:W-1]))
                dist_next[i] = floor_val[i][W-1:0];
            else if (floor_val[i][SW-1])
                dist_next[i] = rbst_pkg::COORD_MIN;
            else
                dist_next[i] = rbst_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        inv_reg <= inv;
        for (int i = 0; i < 2; i++)
        begin
            diff_reg[i]  <= diff_next[i];
            pp_lo_reg[i] <= pp_lo_next[i];
            pp_hi_reg[i] <= pp_hi_next[i];
            prod_reg[i]  <= prod_next[i];
            dist_reg[i]  <= dist_next[i];
        end
    end

    assign t.tn = dist_reg[0];
    assign t.tf = dist_reg[1];

endmodule

@@ hw/rtl/rbst_merge.sv @@
module rbst_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  rbst_pkg::axis_t   tx,
    input  rbst_pkg::axis_t   ty,
    input  rbst_pkg::axis_t   tz,
    output logic              done,
    output rbst_pkg::result_t result
);

    logic              valid_reg;
    logic              done_reg;
    logic              miss_reg;
    logic              miss_next;
    rbst_pkg::axis_t   span_reg;
    rbst_pkg::axis_t   span_next;
    rbst_pkg::axis_t   tz_reg;
    rbst_pkg::result_t result_reg;
    rbst_pkg::result_t result_next;
    logic              miss_z;

    always_comb
    begin
        miss_next    = (tx.tn > ty.tf) || (ty.tn > tx.tf);
        span_next.tn = (ty.tn > tx.tn) ? ty.tn : tx.tn;
        span_next.tf = (ty.tf < tx.tf) ? ty.tf : tx.tf;

        miss_z = miss_reg || (span_reg.tn > tz_reg.tf) || (tz_reg.tn > span_reg.tf);
        result_next.hit = !miss_z;
        if (miss_z)
        begin
            result_next.t_near = '0;
            result_next.t_far  = '0;
        end
        else
        begin
            result_next.t_near = (tz_reg.tn > span_reg.tn) ? tz_reg.tn : span_reg.tn;
            result_next.t_far  = (tz_reg.tf < span_reg.tf) ? tz_reg.tf : span_reg.tf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        miss_reg   <= miss_next;
        span_reg   <= span_next;
        tz_reg     <= tz;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/ray_box_slab_test.sv @@
// Ray versus axis-aligned box, slab method, signed fixed point (Q16.16 by
// default). Load the six box bounds through the cfg port while idle; after
// reset the box is empty and every ray misses. A request is taken on any
// cycle with start high (busy is never raised), one per clock, and its
// result appears with done for a single cycle. The receiver cannot stall,
// so capture result whenever done is high. Each request passes through the
// per-axis datapath (bound select and subtract, two partial products,
// product sum, floor shift with saturation) and then two compare-and-narrow
// stages. On a miss hit is 0 and both distances are 0.
module ray_box_slab_test #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rbst_pkg::request_t                   request,
    output logic                                 done,
    output rbst_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbst_pkg::COORD_WIDTH-1:0]     cfg_data
);

    localparam int W = rbst_pkg::COORD_WIDTH;

    logic signed [W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [W-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic [3:0]          valid_reg;
    rbst_pkg::axis_t     tx, ty, tz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= rbst_pkg::COORD_MAX;
            min_y_reg <= rbst_pkg::COORD_MAX;
            min_z_reg <= rbst_pkg::COORD_MAX;
            max_x_reg <= rbst_pkg::COORD_MIN;
            max_y_reg <= rbst_pkg::COORD_MIN;
            max_z_reg <= rbst_pkg::COORD_MIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbst_pkg::REG_BOX_MIN_X: min_x_reg <= cfg_data;
                rbst_pkg::REG_BOX_MIN_Y: min_y_reg <= cfg_data;
                rbst_pkg::REG_BOX_MIN_Z: min_z_reg <= cfg_data;
                rbst_pkg::REG_BOX_MAX_X: max_x_reg <= cfg_data;
                rbst_pkg::REG_BOX_MAX_Y: max_y_reg <= cfg_data;
                rbst_pkg::REG_BOX_MAX_Z: max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid tracks the four slab stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], start};
    end

    assign busy = 1'b0;

    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
        .clk  (clk),
        .lo_b (min_x_reg),
        .hi_b (max_x_reg),
        .org  (request.origin_x),
        .inv  (request.inv_dir_x),
        .neg  (request.neg_x),
        .t    (tx)
    );

    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
        .clk  (clk),
        .lo_b (min_y_reg),
        .hi_b (max_y_reg),
        .org  (request.origin_y),
        .inv  (request.inv_dir_y),
        .neg  (request.neg_y),
        .t    (ty)
    );

    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
        .clk  (clk),
        .lo_b (min_z_reg),
        .hi_b (max_z_reg),
        .org  (request.origin_z),
        .inv  (request.inv_dir_z),
        .neg  (request.neg_z),
        .t    (tz)
    );

    rbst_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (valid_reg[3]),
        .tx     (tx),
        .ty     (ty),
        .tz     (tz),
        .done   (done),
        .result (result)
    );

endmodule
